FILE: sv/nfa_pkg.sv
// Shared types and constants of the Thompson NFA matcher.
package nfa_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_SPLIT   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;

    localparam int CHUNK_MAX = 32;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [7:0] na;
        logic       na_ok;
        logic [7:0] nb;
        logic       nb_ok;
    } t_node;

    typedef struct packed {
        t_cmd       cmd;
        logic       load_ok;
        logic [7:0] index;
        t_node      node;
        logic [7:0] text_byte;
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEED,
        ST_POP,
        ST_STK,
        ST_EVAL,
        ST_PUSHA,
        ST_COPY,
        ST_RPT,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/nfa_front.sv
// Front end: accepts input words, classifies them and queues them for the engine.
module nfa_front #(
    parameter int NODES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_cmd,
    input  logic [7:0]     i_entry_index,
    input  logic [1:0]     i_entry_kind,
    input  logic [7:0]     i_entry_char,
    input  logic [7:0]     i_next_a,
    input  logic           i_next_a_present,
    input  logic [7:0]     i_next_b,
    input  logic           i_next_b_present,
    input  logic [7:0]     i_text_byte,
    output logic           o_op_valid,
    output nfa_pkg::t_op   o_op,
    input  logic           i_op_ready
);

    nfa_pkg::t_op r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    nfa_pkg::t_op op_in;
    logic         push, pop;

    always_comb begin
        op_in.cmd        = nfa_pkg::t_cmd'(i_cmd);
        op_in.load_ok    = (int'(i_entry_index) < NODES);
        op_in.index      = i_entry_index;
        op_in.node.kind  = i_entry_kind;
        op_in.node.ch    = i_entry_char;
        op_in.node.na    = i_next_a;
        op_in.node.na_ok = i_next_a_present;
        op_in.node.nb    = i_next_b;
        op_in.node.nb_ok = i_next_b_present;
        op_in.text_byte  = i_text_byte;
    end

    assign o_stall    = (r_cnt == 2'd2);
    assign push       = i_valid && !o_stall;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= op_in;
    end

endmodule

FILE: sv/nfa_engine.sv
// Back end: node table, active set scan, epsilon closure and result register.
module nfa_engine #(
    parameter int NODES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_start,
    input  logic           i_op_valid,
    input  nfa_pkg::t_op   i_op,
    output logic           o_op_ready,
    output logic           o_valid,
    output logic           o_live,
    output logic           o_matched,
    input  logic           i_stall
);

    localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CH  = (NODES < nfa_pkg::CHUNK_MAX) ? NODES : nfa_pkg::CHUNK_MAX;
    localparam int NC  = (NODES + CH - 1) / CH;
    localparam int NP  = NC * CH;
    localparam int CCW = (NC > 1) ? $clog2(NC) : 1;
    localparam int JW  = (CH > 1) ? $clog2(CH) : 1;

    nfa_pkg::t_state r_state, n_state;

    nfa_pkg::t_node mem [NODES];
    logic [IW-1:0]  stk [NODES];

    logic [NP-1:0]  r_active, n_active;
    logic [NP-1:0]  r_next, n_next;
    logic [NP-1:0]  r_visited, n_visited;
    logic [NP-1:0]  r_accv;
    logic [CCW-1:0] r_chunk, n_chunk;
    logic [CH-1:0]  r_pend, n_pend;
    logic [IW:0]    r_sp, n_sp;
    logic [IW-1:0]  r_stk_q, r_cur;
    nfa_pkg::t_node r_rd;
    nfa_pkg::t_op   r_op;
    logic           r_live_acc, n_live_acc, r_match_acc, n_match_acc;
    logic           r_ovalid, r_live, r_match;

    logic           take, last, out_free, rd_en;
    logic [JW-1:0]  j;
    logic [IW-1:0]  scan_addr, rd_addr, cand_idx;
    logic [IW:0]    sp_m1;
    logic [7:0]     cand;
    logic           cand_ok, push_en;
    logic [CH-1:0]  chunk_act, chunk_acc;

    assign o_op_ready = (r_state == nfa_pkg::ST_IDLE);
    assign take       = i_op_valid && o_op_ready;
    assign last       = (r_chunk == CCW'(NC - 1));
    assign out_free   = !r_ovalid || !i_stall;
    assign chunk_act  = r_active[int'(r_chunk) * CH +: CH];
    assign chunk_acc  = r_accv[int'(r_chunk) * CH +: CH];
    assign sp_m1      = r_sp - 1'b1;

    // Lowest pending node of the current chunk.
    always_comb begin
        j = '0;
        for (int k = CH - 1; k >= 0; k--) begin
            if (r_pend[k]) j = JW'(k);
        end
    end

    assign scan_addr = IW'(int'(r_chunk) * CH + int'(j));
    assign rd_en     = ((r_state == nfa_pkg::ST_SCAN) && (r_pend != '0)) ||
                       (r_state == nfa_pkg::ST_STK);
    assign rd_addr   = (r_state == nfa_pkg::ST_SCAN) ? scan_addr : r_stk_q;

    // Candidate for the work stack.
    always_comb begin
        cand    = r_rd.na;
        cand_ok = 1'b0;
        case (r_state)
            nfa_pkg::ST_IDLE: begin
                cand    = i_start;
                cand_ok = take && (i_op.cmd == nfa_pkg::CMD_BEGIN);
            end
            nfa_pkg::ST_SEED: begin
                cand    = r_rd.na;
                cand_ok = (r_rd.kind == nfa_pkg::KIND_LITERAL) &&
                          (r_rd.ch == r_op.text_byte) && r_rd.na_ok;
            end
            nfa_pkg::ST_EVAL: begin
                cand    = r_rd.nb;
                cand_ok = (r_rd.kind == nfa_pkg::KIND_SPLIT) && r_rd.nb_ok;
            end
            nfa_pkg::ST_PUSHA: begin
                cand    = r_rd.na;
                cand_ok = r_rd.na_ok;
            end
            default: begin
                cand    = r_rd.na;
                cand_ok = 1'b0;
            end
        endcase
    end

    assign cand_idx = IW'(cand);
    assign push_en  = cand_ok && (int'(cand) < NODES) &&
                      ((r_state == nfa_pkg::ST_IDLE) || !r_visited[cand_idx]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nfa_pkg::ST_IDLE: begin
                if (take) begin
                    unique case (i_op.cmd)
                        nfa_pkg::CMD_BEGIN: n_state = nfa_pkg::ST_POP;
                        nfa_pkg::CMD_TEXT:  n_state = nfa_pkg::ST_SCAN;
                        default:            n_state = nfa_pkg::ST_RPT;
                    endcase
                end
            end
            nfa_pkg::ST_SCAN: begin
                if (r_pend != '0) n_state = nfa_pkg::ST_SEED;
                else if (last) n_state = nfa_pkg::ST_COPY;
            end
            nfa_pkg::ST_SEED: n_state = nfa_pkg::ST_POP;
            nfa_pkg::ST_POP: begin
                if (r_sp != '0) n_state = nfa_pkg::ST_STK;
                else if (r_op.cmd == nfa_pkg::CMD_TEXT) n_state = nfa_pkg::ST_SCAN;
                else n_state = nfa_pkg::ST_COPY;
            end
            nfa_pkg::ST_STK: n_state = nfa_pkg::ST_EVAL;
            nfa_pkg::ST_EVAL: begin
                if (r_rd.kind == nfa_pkg::KIND_SPLIT) n_state = nfa_pkg::ST_PUSHA;
                else n_state = nfa_pkg::ST_POP;
            end
            nfa_pkg::ST_PUSHA: n_state = nfa_pkg::ST_POP;
            nfa_pkg::ST_COPY:  n_state = nfa_pkg::ST_RPT;
            nfa_pkg::ST_RPT: begin
                if (last) n_state = nfa_pkg::ST_EMIT;
            end
            nfa_pkg::ST_EMIT: begin
                if (out_free) n_state = nfa_pkg::ST_IDLE;
            end
            default: n_state = nfa_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_active    = r_active;
        n_next      = r_next;
        n_visited   = r_visited;
        n_chunk     = r_chunk;
        n_pend      = r_pend;
        n_sp        = r_sp;
        n_live_acc  = r_live_acc;
        n_match_acc = r_match_acc;

        if (take) begin
            n_chunk     = '0;
            n_live_acc  = 1'b0;
            n_match_acc = 1'b0;
            if ((i_op.cmd == nfa_pkg::CMD_BEGIN) || (i_op.cmd == nfa_pkg::CMD_TEXT)) begin
                n_visited = '0;
                n_next    = '0;
            end
            n_pend = r_active[CH-1:0];
        end

        if (r_state == nfa_pkg::ST_SCAN) begin
            if (r_pend != '0) begin
                n_pend[j] = 1'b0;
            end else if (!last) begin
                n_chunk = r_chunk + 1'b1;
                n_pend  = r_active[(int'(r_chunk) + 1) * CH +: CH];
            end
        end

        if ((r_state == nfa_pkg::ST_POP) && (r_sp != '0)) n_sp = sp_m1;

        if ((r_state == nfa_pkg::ST_EVAL) && (r_rd.kind != nfa_pkg::KIND_SPLIT)) begin
            n_next[r_cur] = 1'b1;
        end

        if (push_en) begin
            n_visited[cand_idx] = 1'b1;
            n_sp                = r_sp + 1'b1;
        end

        if (r_state == nfa_pkg::ST_COPY) begin
            n_active    = r_next;
            n_chunk     = '0;
            n_live_acc  = 1'b0;
            n_match_acc = 1'b0;
        end

        if (r_state == nfa_pkg::ST_RPT) begin
            n_live_acc  = r_live_acc | (|chunk_act);
            n_match_acc = r_match_acc | (|(chunk_act & chunk_acc));
            if (!last) n_chunk = r_chunk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfa_pkg::ST_IDLE;
            r_active  <= '0;
            r_next    <= '0;
            r_visited <= '0;
            r_sp      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_next    <= n_next;
            r_visited <= n_visited;
            r_sp      <= n_sp;
            if ((r_state == nfa_pkg::ST_EMIT) && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk     <= n_chunk;
        r_pend      <= n_pend;
        r_live_acc  <= n_live_acc;
        r_match_acc <= n_match_acc;
        if (take) r_op <= i_op;
        if ((r_state == nfa_pkg::ST_EMIT) && out_free) begin
            r_live  <= r_live_acc;
            r_match <= r_match_acc;
        end
        if (r_state == nfa_pkg::ST_STK) r_cur <= r_stk_q;
    end

    // Node table and its accept shadow bits.
    always_ff @(posedge i_clk) begin
        if (take && (i_op.cmd == nfa_pkg::CMD_LOAD) && i_op.load_ok) begin
            mem[IW'(i_op.index)]    <= i_op.node;
            r_accv[IW'(i_op.index)] <= (i_op.node.kind == nfa_pkg::KIND_ACCEPT);
        end
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // Work stack.
    always_ff @(posedge i_clk) begin
        if (push_en) stk[r_sp[IW-1:0]] <= cand_idx;
        if ((r_state == nfa_pkg::ST_POP) && (r_sp != '0)) r_stk_q <= stk[sp_m1[IW-1:0]];
    end

    assign o_valid   = r_ovalid;
    assign o_live    = r_live;
    assign o_matched = r_match;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sp) <= NODES)
        else $error("work stack pointer beyond node count");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfa_pkg::ST_POP && r_sp != '0) |=> (r_sp == $past(sp_m1)))
        else $error("pop did not shrink the work stack");

    a_push_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |=> r_visited[$past(cand_idx)])
        else $error("pushed node not marked visited");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfa_pkg::ST_EMIT && r_ovalid && i_stall) |=> (r_state == nfa_pkg::ST_EMIT))
        else $error("result left while output register was blocked");

endmodule

FILE: sv/nfa_regex_matcher.sv
// Top level of the Thompson NFA matcher: start register, front end and engine.
//
//  Channel   Direction  Handshake               Word
//  in        input      i_valid / o_stall       cmd, node entry fields, text byte
//  out       output     o_valid / i_stall       live, matched
//  cfg       input      i_cfg_valid/o_cfg_ready start node index
//
// The active set is kept in NC = ceil(NODES/32) chunks. A load word writes the node table;
// it and an end-of-text word then only report, walking the chunks for live and accept nodes.
// A begin word follows the closure of the start node through the work stack, one node at
// a time, then copies the new set and reports. A text word walks the active set, seeds the
// stack from each active literal that matches the byte, follows the closures, then copies
// and reports. Every node visit goes through the single read port of the node table.
// Reset is synchronous and active low; it empties the active set and the queue,
// and the node table holds no data until it is loaded.
// A stall on the output holds the result register; the engine waits in its
// report state and the two-word input queue keeps taking words until it fills.
module nfa_regex_matcher #(
    parameter int NODES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [1:0] i_entry_kind,
    input  logic [7:0] i_entry_char,
    input  logic [7:0] i_next_a,
    input  logic       i_next_a_present,
    input  logic [7:0] i_next_b,
    input  logic       i_next_b_present,
    input  logic [7:0] i_text_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_live,
    output logic       o_matched,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // Always-ready start node register; the user must write it only while idle (unchecked).
    logic [7:0]   r_start_node;
    logic         op_valid, op_ready;
    nfa_pkg::t_op op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_node <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_node <= i_cfg_data;
        end
    end

    // The front end classifies each word and buffers it so the input side
    // keeps moving while the engine works through a closure.
    nfa_front #(.NODES(NODES)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_entry_index    (i_entry_index),
        .i_entry_kind     (i_entry_kind),
        .i_entry_char     (i_entry_char),
        .i_next_a         (i_next_a),
        .i_next_a_present (i_next_a_present),
        .i_next_b         (i_next_b),
        .i_next_b_present (i_next_b_present),
        .i_text_byte      (i_text_byte),
        .o_op_valid       (op_valid),
        .o_op             (op),
        .i_op_ready       (op_ready)
    );

    // The engine owns the node table and the node sets and produces one
    // result word for every word it takes.
    nfa_engine #(.NODES(NODES)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start_node),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_ready (op_ready),
        .o_valid    (o_valid),
        .o_live     (o_live),
        .o_matched  (o_matched),
        .i_stall    (i_stall)
    );

endmodule

FILE: tb/nfa_checker.sv
// Checker of the NFA matcher: mirrors the node table and active set and compares each result word.
module nfa_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [1:0] i_entry_kind,
    input  logic [7:0] i_entry_char,
    input  logic [7:0] i_next_a,
    input  logic       i_next_a_present,
    input  logic [7:0] i_next_b,
    input  logic       i_next_b_present,
    input  logic [7:0] i_text_byte,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic       o_live,
    input  logic       o_matched,
    input  logic       i_cfg_valid,
    input  logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic live;
        logic matched;
    } t_status;

    nfa_pkg::t_node node_mem [256];
    bit             active [256];
    bit             seen [256];
    bit             reached [256];
    logic [7:0]     start_idx;
    t_status        status_q [$];

    assign pending = status_q.size();

    // Adds the epsilon closure of one node to the reached set.
    function automatic void close_over(logic [7:0] idx, logic ok);
        logic [7:0] stack [$];
        logic [7:0] cur;
        if (!ok || seen[idx]) return;
        seen[idx] = 1'b1;
        stack.push_back(idx);
        while (stack.size() > 0) begin
            cur = stack.pop_back();
            if (node_mem[cur].kind == nfa_pkg::KIND_SPLIT) begin
                if (node_mem[cur].nb_ok && !seen[node_mem[cur].nb]) begin
                    seen[node_mem[cur].nb] = 1'b1;
                    stack.push_back(node_mem[cur].nb);
                end
                if (node_mem[cur].na_ok && !seen[node_mem[cur].na]) begin
                    seen[node_mem[cur].na] = 1'b1;
                    stack.push_back(node_mem[cur].na);
                end
            end else begin
                reached[cur] = 1'b1;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_status st;
        t_status got;
        if (!i_rst_n) begin
            active = '{default: 1'b0};
            start_idx = 8'd0;
            status_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                start_idx = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                case (nfa_pkg::t_cmd'(i_cmd))
                    nfa_pkg::CMD_LOAD: begin
                        node_mem[i_entry_index] = '{i_entry_kind, i_entry_char, i_next_a,
                                                    i_next_a_present, i_next_b,
                                                    i_next_b_present};
                    end
                    nfa_pkg::CMD_BEGIN: begin
                        seen = '{default: 1'b0};
                        reached = '{default: 1'b0};
                        close_over(start_idx, 1'b1);
                        active = reached;
                    end
                    nfa_pkg::CMD_TEXT: begin
                        seen = '{default: 1'b0};
                        reached = '{default: 1'b0};
                        for (int i = 0; i < 256; i++) begin
                            if (active[i] && node_mem[i].kind == nfa_pkg::KIND_LITERAL &&
                                node_mem[i].ch == i_text_byte) begin
                                close_over(node_mem[i].na, node_mem[i].na_ok);
                            end
                        end
                        active = reached;
                    end
                    default: ;
                endcase
                st = '{1'b0, 1'b0};
                for (int i = 0; i < 256; i++) begin
                    if (active[i]) begin
                        st.live = 1'b1;
                        if (node_mem[i].kind == nfa_pkg::KIND_ACCEPT) st.matched = 1'b1;
                    end
                end
                status_q.push_back(st);
            end
            if (o_valid && !i_stall) begin
                if (status_q.size() == 0) begin
                    $error("result word with nothing expected: live %0b matched %0b",
                           o_live, o_matched);
                    errors++;
                end else begin
                    got = status_q.pop_front();
                    if (o_live !== got.live) begin
                        $error("live: expected %0b, actual %0b", got.live, o_live);
                        errors++;
                    end
                    if (o_matched !== got.matched) begin
                        $error("matched: expected %0b, actual %0b", got.matched, o_matched);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
// Top of the NFA matcher testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the block treats as an inert member of the set.
    localparam logic [1:0] KIND_INERT = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         HOLD_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd = nfa_pkg::CMD_END;
    logic [7:0] i_entry_index = 8'd0;
    logic [1:0] i_entry_kind = nfa_pkg::KIND_LITERAL;
    logic [7:0] i_entry_char = 8'd0;
    logic [7:0] i_next_a = 8'd0;
    logic       i_next_a_present = 1'b0;
    logic [7:0] i_next_b = 8'd0;
    logic       i_next_b_present = 1'b0;
    logic [7:0] i_text_byte = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_live;
    logic       o_matched;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'd0;

    int         fail_count;
    int         pending;

    // Stimulus bookkeeping.
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;
    bit         written [256];
    logic [7:0] written_list [$];
    logic [7:0] cur_start = 8'd0;
    int         word_count = 0;
    int         program_count = 0;
    int         start_writes = 0;
    int         match_count = 0;
    int         quiet_cycles = 0;

    nfa_regex_matcher #(.NODES(256)) DUT (.*);

    nfa_checker u_checker (
        .*,
        .errors (fail_count),
        .pending(pending)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // The watchdog restarts whenever any channel moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
        begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (o_valid && !i_stall && o_matched) match_count <= match_count + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog expired with %0d results outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, none while calm, plus one long hold-off on request so that the
    // block fills its queue and stalls its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    // Offers one word and returns at the edge that accepts it. Valid stays high afterward,
    // so the next word follows back to back unless a gap is drawn.
    task automatic send_word(nfa_pkg::t_cmd c, logic [7:0] idx, logic [1:0] kind,
                             logic [7:0] ch, logic [7:0] na, logic nap, logic [7:0] nb,
                             logic nbp, logic [7:0] text);
        while (!calm && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd            <= c;
        i_entry_index    <= idx;
        i_entry_kind     <= kind;
        i_entry_char     <= ch;
        i_next_a         <= na;
        i_next_a_present <= nap;
        i_next_b         <= nb;
        i_next_b_present <= nbp;
        i_text_byte      <= text;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        word_count++;
        if (c == nfa_pkg::CMD_LOAD && !written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endtask

    task automatic load_node(logic [7:0] idx, logic [1:0] kind, logic [7:0] ch,
                             logic [7:0] na, logic nap, logic [7:0] nb, logic nbp);
        send_word(nfa_pkg::CMD_LOAD, idx, kind, ch, na, nap, nb, nbp, 8'($urandom));
    endtask

    // Non-load words carry random entry fields; the block ignores them.
    task automatic run_cmd(nfa_pkg::t_cmd c, logic [7:0] text);
        send_word(c, 8'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom), 1'($urandom), text);
    endtask

    // Drops valid, then waits until every expected result has drained.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the start node index; the block is idle by then.
    task automatic set_start(logic [7:0] idx);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= idx;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_start = idx;
        start_writes++;
    endtask

    function automatic logic [7:0] pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    // Compiles a short pattern of plain and starred literals into consecutive nodes, points
    // the start register at it, then runs text that mostly follows the pattern.
    task automatic run_program();
        logic [7:0] base;
        logic [7:0] p;
        logic [7:0] chars [$];
        bit         starred [$];
        int         n;
        logic [7:0] b;
        base = 8'($urandom);
        p = base;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            chars.push_back(8'h61 + 8'($urandom_range(2)));
            starred.push_back($urandom_range(2) == 0);
        end
        for (int k = 0; k < n; k++) begin
            if (starred[k]) begin
                load_node(p, nfa_pkg::KIND_SPLIT, 8'($urandom), p + 8'd1, 1'b1, p + 8'd2,
                          1'b1);
                load_node(p + 8'd1, nfa_pkg::KIND_LITERAL, chars[k], p, 1'b1, 8'($urandom),
                          1'b0);
                p = p + 8'd2;
            end else begin
                load_node(p, nfa_pkg::KIND_LITERAL, chars[k], p + 8'd1, 1'b1, 8'($urandom),
                          1'($urandom));
                p = p + 8'd1;
            end
        end
        load_node(p, nfa_pkg::KIND_ACCEPT, 8'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom));
        if (cur_start != base) set_start(base);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'($urandom));
        for (int k = 0; k < n; k++) begin
            repeat (starred[k] ? $urandom_range(2) : 1) begin
                b = ($urandom_range(9) < 2) ? 8'($urandom) : chars[k];
                run_cmd(nfa_pkg::CMD_TEXT, b);
            end
        end
        if ($urandom_range(3) == 0) run_cmd(nfa_pkg::CMD_TEXT, 8'h61 + 8'($urandom_range(2)));
        run_cmd(nfa_pkg::CMD_END, 8'($urandom));
        program_count++;
    endtask

    // Noise: loads whose successors only name loaded nodes, and stray commands.
    task automatic run_noise();
        logic nap;
        logic nbp;
        case ($urandom_range(3))
            0, 1: begin
                nap = 1'($urandom);
                nbp = 1'($urandom);
                load_node(8'($urandom), 2'($urandom), 8'($urandom),
                          nap ? pick_written() : 8'($urandom), nap,
                          nbp ? pick_written() : 8'($urandom), nbp);
            end
            2: run_cmd(nfa_pkg::CMD_TEXT, 8'($urandom));
            default: run_cmd($urandom_range(1) ? nfa_pkg::CMD_BEGIN : nfa_pkg::CMD_END,
                             8'($urandom));
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Text before any begin finds an empty set.
        run_cmd(nfa_pkg::CMD_TEXT, 8'h41);
        load_node(8'd0, nfa_pkg::KIND_ACCEPT, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'h00);
        run_cmd(nfa_pkg::CMD_END, 8'hFF);
        // Top index, all-ones byte; a literal ignores its second successor.
        load_node(8'd255, nfa_pkg::KIND_LITERAL, 8'hFF, 8'h00, 1'b1, 8'hFF, 1'b1);
        set_start(8'd255);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'h00);
        run_cmd(nfa_pkg::CMD_TEXT, 8'hFF);
        run_cmd(nfa_pkg::CMD_TEXT, 8'h00);
        run_cmd(nfa_pkg::CMD_TEXT, 8'h00);
        // A split reaching an inert node and the accept node; neither consumes a byte.
        load_node(8'd1, KIND_INERT, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
        load_node(8'd2, nfa_pkg::KIND_SPLIT, 8'h00, 8'd1, 1'b1, 8'd0, 1'b1);
        set_start(8'd2);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'h00);
        run_cmd(nfa_pkg::CMD_TEXT, 8'h00);
        // A split looping on itself has an empty closure.
        load_node(8'd3, nfa_pkg::KIND_SPLIT, 8'h00, 8'd3, 1'b1, 8'd3, 1'b1);
        set_start(8'd3);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'h00);
        // A literal on byte zero looping on itself.
        load_node(8'd4, nfa_pkg::KIND_LITERAL, 8'h00, 8'd4, 1'b1, 8'h00, 1'b0);
        set_start(8'd4);
        run_cmd(nfa_pkg::CMD_BEGIN, 8'h00);
        run_cmd(nfa_pkg::CMD_TEXT, 8'h00);
        run_cmd(nfa_pkg::CMD_END, 8'h00);
        set_start(8'd0);

        // Random part: mostly well-formed programs, some noise, one calm stretch, one
        // long receiver hold-off and one full pause of the sender.
        while (word_count < 650) begin
            if (program_count == 20) calm = 1'b1;
            if (program_count == 35) calm = 1'b0;
            if (word_count > 350 && word_count < 360) hold_req = 1'b1;
            if (program_count == 50) drain();
            if ($urandom_range(9) < 7) begin
                run_program();
            end else begin
                repeat ($urandom_range(1, 4)) run_noise();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Ran %0d words: %0d compiled patterns, %0d start node writes,", word_count,
                 program_count, start_writes);
        $display("with %0d full-string matches reported.", match_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
